/* hw/rtl/rcs_pkg.sv */
package rcs_pkg;

  // Geometry and scale.
  localparam int GRID_SIDE     = 16;
  localparam int GRID_BITS     = 4;
  localparam int CELL_BITS     = 2 * GRID_BITS;
  localparam int KIND_W        = 3;
  localparam int COL_W         = 7;
  localparam int ROW_W         = 7;
  localparam int POS_W         = 16;
  localparam int ANG_W         = 12;
  localparam int STEP_W        = 12;
  localparam int COLOR_W       = 16;
  localparam int TRIG_W        = 16;
  localparam int MAG_W         = 15;
  localparam int SCREEN_HEIGHT = 96;
  localparam int MAX_DISTANCE  = 16;

  // APB register file.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Datapath widths.
  localparam int DIST_W    = 19;
  localparam int MARCH_W   = 17;
  localparam int PROD_W    = 34;
  localparam int SUM_W     = 35;
  localparam int POS_FRAC  = 14;
  localparam int CELL_FRAC = 26;
  localparam int QUO_W     = 31;
  localparam int CNT_W     = 5;
  localparam int CEIL_W    = 33;

  localparam logic [DIST_W-1:0] DIST_FAR   = DIST_W'(SCREEN_HEIGHT * 4096);
  localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(MAX_DISTANCE * 4096);
  localparam logic [QUO_W-1:0]  DIV_DIVIDEND = QUO_W'(SCREEN_HEIGHT * (2 ** 24));
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(QUO_W - 1);
  localparam logic [CEIL_W-1:0] HALF_ROWS_Q12 = CEIL_W'((SCREEN_HEIGHT / 2) * 4096);
  localparam logic [ANG_W-1:0]  ANG_QUARTER = ANG_W'(1024);
  localparam logic [ANG_W-1:0]  ANG_BACK    = ANG_W'(4096 - 512);
  localparam logic [MAG_W-1:0]  Q14_ONE     = MAG_W'(16384);
  // floor(n/3) as (n * 21846) >> 16 is exact for every n below 32768.
  localparam logic [15:0]       THIRD_RECIP = 16'd21846;

  // Register indexes.
  localparam logic [2:0] REG_STEP_SIZE    = 3'd0;
  localparam logic [2:0] REG_CEILING      = 3'd1;
  localparam logic [2:0] REG_FLOOR        = 3'd2;
  localparam logic [2:0] REG_WALL_ONE     = 3'd3;
  localparam logic [2:0] REG_WALL_TWO     = 3'd4;
  localparam logic [2:0] REG_WALL_THREE   = 3'd5;
  localparam logic [2:0] REG_WALL_FOUR    = 3'd6;

  // Register reset values.
  localparam logic [STEP_W-1:0]  RST_STEP_SIZE  = 12'd410;
  localparam logic [COLOR_W-1:0] RST_CEILING    = 16'h1230;
  localparam logic [COLOR_W-1:0] RST_FLOOR      = 16'h4caa;
  localparam logic [COLOR_W-1:0] RST_WALL_ONE   = 16'h3333;
  localparam logic [COLOR_W-1:0] RST_WALL_TWO   = 16'h0103;
  localparam logic [COLOR_W-1:0] RST_WALL_THREE = 16'h0103;
  localparam logic [COLOR_W-1:0] RST_WALL_FOUR  = 16'h0caa;

  // Command and cell kind codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TWO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_THREE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FOUR  = 3'd4;

  // Quarter-wave sine table, Q1.14.
  localparam logic [MAG_W-1:0] QTAB [17] = '{
    15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102, 15'd10394,
    15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137, 15'd15679, 15'd16069,
    15'd16305, 15'd16384
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_SIN_RAY, ST_COS_RAY, ST_COS_OFF, ST_MUL, ST_ADDR,
    ST_CHECK, ST_CORR, ST_DIV_INIT, ST_DIV, ST_OUT
  } rcs_state_e;

  typedef enum logic [1:0] {
    TRIG_SIN_RAY, TRIG_COS_RAY, TRIG_COS_OFF
  } rcs_trig_e;

  typedef struct packed {
    logic [STEP_W-1:0]  step_size;
    logic [COLOR_W-1:0] wall_one;
    logic [COLOR_W-1:0] wall_two;
    logic [COLOR_W-1:0] wall_three;
    logic [COLOR_W-1:0] wall_four;
  } rcs_cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic      cell_wr;
    logic      cast_ld;
    logic      angle_ld;
    logic      trig_ld;
    rcs_trig_e trig_sel;
    logic      mul_ld;
    logic      rd_en;
    logic      d_far;
    logic      d_next;
    logic      d_corr;
    logic      kind_ld;
    logic      div_init;
    logic      div_step;
    logic      out_ld;
  } rcs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic outside;
    logic is_wall;
    logic below_limit;
    logic div_last;
    logic out_free;
  } rcs_status_t;

  // Angle offset of a column from the view direction, before the back shift.
  function automatic logic [ANG_W-1:0] col_spread(input logic [COL_W-1:0] col);
    logic [ANG_W-1:0] n;
    logic [27:0]      p;
    n = {col, 5'b0};
    p = 28'(n) * 28'(THIRD_RECIP);
    return p[27:16];
  endfunction

  // Interpolated sine, Q1.14, of an angle in 1/4096 turn.
  function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [ANG_W-1:0] a);
    logic [15:0]      ph;
    logic [1:0]       quad;
    logic [MAG_W-1:0] w;
    logic [4:0]       i;
    logic [9:0]       f;
    logic [MAG_W-1:0] lo;
    logic [MAG_W-1:0] hi;
    logic [11:0]      diff;
    logic [21:0]      prod;
    logic [MAG_W-1:0] mag;
    ph   = {a, 4'b0};
    quad = ph[15:14];
    w    = {1'b0, ph[13:0]};
    if (quad[0]) begin
      w = Q14_ONE - w;
    end
    i    = w[14:10];
    f    = w[9:0];
    lo   = QTAB[{1'b0, i[3:0]}];
    hi   = QTAB[{1'b0, i[3:0]} + 5'd1];
    diff = 12'(hi - lo);
    prod = 22'(diff) * 22'(f);
    if (i[4]) begin
      mag = Q14_ONE;
    end else begin
      mag = lo + MAG_W'(prod[21:10]);
    end
    if (quad[1]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

endpackage

/* hw/rtl/rcs_cmd_if.sv */
interface rcs_cmd_if import rcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [7:0]        cell_index;
  logic [KIND_W-1:0] cell_kind;
  logic [COL_W-1:0]  column;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [ANG_W-1:0]  view_angle;

  modport source (output valid, command, cell_index, cell_kind, column, pos_x, pos_y,
                  view_angle, input ready);
  modport sink (input valid, command, cell_index, cell_kind, column, pos_x, pos_y,
                view_angle, output ready);
endinterface

/* hw/rtl/rcs_span_if.sv */
interface rcs_span_if import rcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        column_out;
  logic signed [ROW_W-1:0] ceiling_row;
  logic [ROW_W-1:0]        floor_row;
  logic [COLOR_W-1:0]      wall_color;
  logic [KIND_W-1:0]       wall_kind;

  modport source (output valid, column_out, ceiling_row, floor_row, wall_color, wall_kind,
                  input ready);
  modport sink (input valid, column_out, ceiling_row, floor_row, wall_color, wall_kind,
                output ready);
endinterface

/* hw/rtl/rcs_ram.sv */
module rcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* hw/rtl/rcs_regs.sv */
module rcs_regs import rcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output rcs_cfg_t          cfg_o
);
  rcs_cfg_t           cfg_q;
  logic [COLOR_W-1:0] ceiling_q;
  logic [COLOR_W-1:0] floor_q;
  logic               wr_en;
  logic [2:0]         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  // Register writes on the access beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size  <= RST_STEP_SIZE;
      cfg_q.wall_one   <= RST_WALL_ONE;
      cfg_q.wall_two   <= RST_WALL_TWO;
      cfg_q.wall_three <= RST_WALL_THREE;
      cfg_q.wall_four  <= RST_WALL_FOUR;
      ceiling_q        <= RST_CEILING;
      floor_q          <= RST_FLOOR;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEP_SIZE:  cfg_q.step_size  <= pwdata[STEP_W-1:0];
        REG_CEILING:    ceiling_q        <= pwdata[COLOR_W-1:0];
        REG_FLOOR:      floor_q          <= pwdata[COLOR_W-1:0];
        REG_WALL_ONE:   cfg_q.wall_one   <= pwdata[COLOR_W-1:0];
        REG_WALL_TWO:   cfg_q.wall_two   <= pwdata[COLOR_W-1:0];
        REG_WALL_THREE: cfg_q.wall_three <= pwdata[COLOR_W-1:0];
        REG_WALL_FOUR:  cfg_q.wall_four  <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_STEP_SIZE:  prdata = APB_DW'(cfg_q.step_size);
      REG_CEILING:    prdata = APB_DW'(ceiling_q);
      REG_FLOOR:      prdata = APB_DW'(floor_q);
      REG_WALL_ONE:   prdata = APB_DW'(cfg_q.wall_one);
      REG_WALL_TWO:   prdata = APB_DW'(cfg_q.wall_two);
      REG_WALL_THREE: prdata = APB_DW'(cfg_q.wall_three);
      REG_WALL_FOUR:  prdata = APB_DW'(cfg_q.wall_four);
      default:        prdata = '0;
    endcase
  end
endmodule

/* hw/rtl/rcs_ctrl.sv */
module rcs_ctrl import rcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_command_i,
  output logic        in_ready_o,
  input  rcs_status_t status_i,
  output rcs_cmd_t    cmd_o
);
  rcs_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_command_i == CMD_CAST)) begin
          state_d = ST_ANGLE;
        end
      end
      ST_ANGLE:   state_d = ST_SIN_RAY;
      ST_SIN_RAY: state_d = ST_COS_RAY;
      ST_COS_RAY: state_d = ST_COS_OFF;
      ST_COS_OFF: state_d = ST_MUL;
      ST_MUL:     state_d = ST_ADDR;
      ST_ADDR: begin
        state_d = status_i.outside ? ST_DIV_INIT : ST_CHECK;
      end
      ST_CHECK: begin
        priority if (status_i.is_wall) begin
          state_d = ST_CORR;
        end else if (status_i.below_limit) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_CORR:     state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.trig_sel = TRIG_SIN_RAY;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.cell_wr = accept && (in_command_i == CMD_WRITE);
        cmd_o.cast_ld = accept && (in_command_i == CMD_CAST);
      end
      ST_ANGLE: cmd_o.angle_ld = 1'b1;
      ST_SIN_RAY: begin
        cmd_o.trig_ld  = 1'b1;
        cmd_o.trig_sel = TRIG_SIN_RAY;
      end
      ST_COS_RAY: begin
        cmd_o.trig_ld  = 1'b1;
        cmd_o.trig_sel = TRIG_COS_RAY;
      end
      ST_COS_OFF: begin
        cmd_o.trig_ld  = 1'b1;
        cmd_o.trig_sel = TRIG_COS_OFF;
      end
      ST_MUL: cmd_o.mul_ld = 1'b1;
      ST_ADDR: begin
        cmd_o.d_far = status_i.outside;
        cmd_o.rd_en = !status_i.outside;
      end
      ST_CHECK: begin
        cmd_o.kind_ld = status_i.is_wall;
        cmd_o.d_next  = !status_i.is_wall && status_i.below_limit;
      end
      ST_CORR:     cmd_o.d_corr   = 1'b1;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_OUT:      cmd_o.out_ld   = status_i.out_free;
      default: ;
    endcase
  end
endmodule

/* hw/rtl/rcs_dp.sv */
module rcs_dp import rcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rcs_cfg_t     cfg_i,
  input  rcs_cmd_t     cmd_i,
  output rcs_status_t  status_o,
  rcs_cmd_if.sink      in_i,
  rcs_span_if.source   out_o
);
  // Cast operands.
  logic [COL_W-1:0]  col_q;
  logic [POS_W-1:0]  posx_q, posy_q;
  logic [ANG_W-1:0]  view_q, off_q, ray_q, off_d, trig_ang;
  logic signed [TRIG_W-1:0] sx_q, sy_q, trig;
  logic [MAG_W-1:0]  acos_q;

  // March state.
  logic [DIST_W-1:0] d_q, d_d;
  logic [STEP_W-1:0] step_eff;
  logic signed [PROD_W-1:0] prodx_q, prody_q;
  logic signed [SUM_W-1:0]  sumx, sumy;
  logic              outx, outy;
  logic [GRID_BITS-1:0] cx, cy;
  logic [CELL_BITS-1:0] rd_addr;
  logic [(1 << CELL_BITS)-1:0] cell_vld_q;
  logic              rd_vld_q;
  logic [KIND_W-1:0] ram_rdata, kind_rd, last_kind_q;
  logic [31:0]       corr_prod;

  // Divider.
  logic [DIST_W-1:0] rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIST_W:0]   trial;
  logic              ge;

  // Result.
  logic signed [CEIL_W-1:0] v;
  logic [ROW_W-1:0]  ceil_row;
  logic [COLOR_W-1:0] color;
  logic              out_valid_q;

  rcs_ram #(.WIDTH(KIND_W), .DEPTH(1 << CELL_BITS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cell_wr),
    .waddr_i (in_i.cell_index),
    .wdata_i (in_i.cell_kind),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Written-cell flags; an unwritten cell reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      last_kind_q <= KIND_ONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cell_wr) begin
        cell_vld_q[in_i.cell_index] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= cell_vld_q[rd_addr];
      end
      if (cmd_i.kind_ld) begin
        last_kind_q <= kind_rd;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ray and offset angles.
  assign off_d = ANG_BACK + col_spread(col_q);

  // Shared sine unit.
  always_comb begin
    unique case (cmd_i.trig_sel)
      TRIG_SIN_RAY: trig_ang = ray_q;
      TRIG_COS_RAY: trig_ang = ray_q + ANG_QUARTER;
      TRIG_COS_OFF: trig_ang = off_q + ANG_QUARTER;
      default:      trig_ang = ray_q;
    endcase
  end
  assign trig = sin_q14(trig_ang);

  // Probe cell from the registered step products.
  assign sumx = $signed({5'b0, posx_q, {POS_FRAC{1'b0}}}) + SUM_W'(prodx_q);
  assign sumy = $signed({5'b0, posy_q, {POS_FRAC{1'b0}}}) - SUM_W'(prody_q);
  assign outx = sumx[SUM_W-1] ? (sumx <= -$signed(SUM_W'(1) << CELL_FRAC))
                              : (|sumx[SUM_W-2:CELL_FRAC+GRID_BITS]);
  assign outy = sumy[SUM_W-1] ? (sumy <= -$signed(SUM_W'(1) << CELL_FRAC))
                              : (|sumy[SUM_W-2:CELL_FRAC+GRID_BITS]);
  assign cx = sumx[SUM_W-1] ? '0 : sumx[CELL_FRAC+GRID_BITS-1:CELL_FRAC];
  assign cy = sumy[SUM_W-1] ? '0 : sumy[CELL_FRAC+GRID_BITS-1:CELL_FRAC];
  assign rd_addr = {cy, cx};

  assign kind_rd   = rd_vld_q ? ram_rdata : KIND_EMPTY;
  assign step_eff  = (cfg_i.step_size == '0) ? STEP_W'(1) : cfg_i.step_size;
  assign corr_prod = 32'(d_q[MARCH_W-1:0]) * 32'(acos_q);

  // Distance register.
  always_comb begin
    d_d = d_q;
    priority if (cmd_i.angle_ld) begin
      d_d = DIST_W'(step_eff);
    end else if (cmd_i.d_next) begin
      d_d = d_q + DIST_W'(step_eff);
    end else if (cmd_i.d_far) begin
      d_d = DIST_FAR;
    end else if (cmd_i.d_corr) begin
      d_d = DIST_W'(corr_prod[31:POS_FRAC]);
    end
  end

  // Restoring divider step.
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_ld) begin
      col_q  <= in_i.column;
      posx_q <= in_i.pos_x;
      posy_q <= in_i.pos_y;
      view_q <= in_i.view_angle;
    end
    if (cmd_i.angle_ld) begin
      off_q <= off_d;
      ray_q <= view_q + off_d;
    end
    if (cmd_i.trig_ld) begin
      unique case (cmd_i.trig_sel)
        TRIG_SIN_RAY: sx_q <= trig;
        TRIG_COS_RAY: sy_q <= trig;
        TRIG_COS_OFF: acos_q <= trig[TRIG_W-1] ? MAG_W'(-trig) : MAG_W'(trig);
        default: ;
      endcase
    end
    d_q <= d_d;
    if (cmd_i.mul_ld) begin
      prodx_q <= PROD_W'($signed({1'b0, d_q[MARCH_W-1:0]})) * PROD_W'(sx_q);
      prody_q <= PROD_W'($signed({1'b0, d_q[MARCH_W-1:0]})) * PROD_W'(sy_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= DIV_DIVIDEND;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? DIST_W'(trial - {1'b0, d_q}) : trial[DIST_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Ceiling row from the quotient, truncated toward zero and saturated.
  assign v = $signed(HALF_ROWS_Q12) - $signed({2'b0, quo_q});
  always_comb begin
    priority if (d_q == '0) begin
      ceil_row = '1;
    end else if (!v[CEIL_W-1]) begin
      ceil_row = v[ROW_W+11:12];
    end else if (v > -$signed(CEIL_W'(4096))) begin
      ceil_row = '0;
    end else begin
      ceil_row = '1;
    end
  end

  always_comb begin
    unique case (last_kind_q)
      KIND_TWO:   color = cfg_i.wall_two;
      KIND_THREE: color = cfg_i.wall_three;
      KIND_FOUR:  color = cfg_i.wall_four;
      default:    color = cfg_i.wall_one;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_o.column_out  <= col_q;
      out_o.ceiling_row <= $signed(ceil_row);
      out_o.floor_row   <= ROW_W'(8'(SCREEN_HEIGHT) - {ceil_row[ROW_W-1], ceil_row});
      out_o.wall_color  <= color;
      out_o.wall_kind   <= last_kind_q;
    end
  end
  assign out_o.valid = out_valid_q;

  assign status_o.outside     = outx || outy;
  assign status_o.is_wall     = (kind_rd >= KIND_ONE) && (kind_rd <= KIND_FOUR);
  assign status_o.below_limit = d_q < DIST_LIMIT;
  assign status_o.div_last    = cnt_q == DIV_LAST;
  assign status_o.out_free    = !out_valid_q || out_o.ready;
endmodule

/* hw/rtl/raycast_column_span_core.sv */
// Channel   Dir  Handshake      Beat
// cmd_i     in   valid/ready    one write or cast command
// span_o    out  valid/ready    one column span per cast
// APB       in   psel/penable   one register write or read
//
// A cell write is done in the idle state as it is accepted. A cast raises its span beat
// after the march and the row divide: a ray that ends on a wall passes CHECK and CORR,
// one that runs past the range passes CHECK alone, and one that leaves the grid goes on
// from ADDR. A march takes at most ceil(65536/step_size) steps, with a zero step counted
// as one. Each step costs a multiply, a grid read and a check; a radix-2 divider gives the row.
// Reset clears the written-cell flags, so the whole grid reads empty at once.
// A stalled span_o holds its beat; the next command is accepted meanwhile.
module raycast_column_span_core import rcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rcs_cmd_if.sink           cmd_i,
  rcs_span_if.source        span_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);
  rcs_cfg_t    cfg;
  rcs_cmd_t    cmd;
  rcs_status_t status;
  logic        in_ready;

  // The controller decides when a command beat is taken.
  assign cmd_i.ready = in_ready;

  rcs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_i.valid),
    .in_command_i (cmd_i.command),
    .in_ready_o   (in_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rcs_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (cmd_i),
    .out_o    (span_o)
  );
endmodule

/* hw/rtl/rcs_checker.sv */
module rcs_checker import rcs_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    span_valid_i,
  input logic                    span_ready_i,
  input logic [COL_W-1:0]        column_out_i,
  input logic signed [ROW_W-1:0] ceiling_row_i,
  input logic [ROW_W-1:0]        floor_row_i,
  input logic [KIND_W-1:0]       wall_kind_i,
  input logic                    pready_i
);
  // A stalled span beat keeps its column.
  a_span_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i && !span_ready_i |=> span_valid_i && $stable(column_out_i))
    else $error("span beat changed under stall");

  // Floor row mirrors the ceiling row.
  a_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i |-> floor_row_i == ROW_W'(8'(SCREEN_HEIGHT) - 8'(ceiling_row_i)))
    else $error("floor row does not match ceiling row");

  // Ceiling row stays within its saturation range.
  a_ceil_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i |-> (ceiling_row_i >= -7'sd1) && (ceiling_row_i <= 7'sd48))
    else $error("ceiling row out of range");

  // Only wall kinds are reported.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i |-> (wall_kind_i >= KIND_ONE) && (wall_kind_i <= KIND_FOUR))
    else $error("wall kind out of range");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("register port not ready");
endmodule

bind raycast_column_span_core rcs_checker u_rcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .span_valid_i  (span_o.valid),
  .span_ready_i  (span_o.ready),
  .column_out_i  (span_o.column_out),
  .ceiling_row_i (span_o.ceiling_row),
  .floor_row_i   (span_o.floor_row),
  .wall_kind_i   (span_o.wall_kind),
  .pready_i      (pready)
);

/* bench/tb_raycast_column_span_core.sv */
`default_nettype none

module tb_raycast_column_span_core;
  import rcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_UNKNOWN = 7;
  localparam int IDLE_SETTLE = 60;

  typedef struct {
    logic              command;
    logic [7:0]        cell_index;
    logic [KIND_W-1:0] cell_kind;
    logic [COL_W-1:0]  column;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [ANG_W-1:0]  view_angle;
  } cmd_beat_t;

  typedef struct {
    logic [COL_W-1:0]        column_out;
    logic signed [ROW_W-1:0] ceiling_row;
    logic [ROW_W-1:0]        floor_row;
    logic [COLOR_W-1:0]      wall_color;
    logic [KIND_W-1:0]       wall_kind;
  } span_beat_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rcs_cmd_if  cmd();
  rcs_span_if span();

  raycast_column_span_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .span_o  (span),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block's map, wall memory and registers.
  logic [KIND_W-1:0]  grid_shadow [256];
  logic [KIND_W-1:0]  kind_shadow;
  logic [STEP_W-1:0]  step_shadow;
  logic [COLOR_W-1:0] wall_shadow [1:4];

  cmd_beat_t  cmd_pending [$];
  span_beat_t span_expected [$];
  cmd_beat_t  cmd_cur;
  logic       cmd_taken;
  int         burst_left;
  int         gap_left;
  int         mismatches;
  int         cycle_count;

  // Clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Quarter-wave sine in Q1.14 with linear interpolation over the low phase bits.
  function automatic longint trig_sine(input int unsigned ang);
    int unsigned ph;
    int unsigned quad;
    int unsigned w;
    int unsigned idx;
    int unsigned frac;
    longint      mag;
    ph = ((ang % 4096) << 4) & 16'hffff;
    quad = ph >> 14;
    w = ph & 16'h3fff;
    if (quad & 1) begin
      w = 16384 - w;
    end
    idx = w >> 10;
    frac = w & 10'h3ff;
    if (idx >= 16) begin
      mag = 16384;
    end else begin
      mag = QTAB[idx] + (((longint'(QTAB[idx + 1]) - QTAB[idx]) * frac) >> 10);
    end
    return (quad >= 2) ? -mag : mag;
  endfunction

  // March one ray through the shadow map and queue the span it produces.
  task automatic predict_span(input cmd_beat_t c);
    int unsigned spread;
    int unsigned offset;
    int unsigned ray;
    longint      sx;
    longint      sy;
    longint      cos_off;
    longint      d;
    longint      stride;
    longint      cx;
    longint      cy;
    longint      q;
    longint      row;
    logic        done;
    logic [KIND_W-1:0] k;
    span_beat_t  s;
    spread = int'(c.column) * 1024 / 96;
    offset = (4096 - 512 + spread) % 4096;
    ray = (c.view_angle + offset) % 4096;
    sx = trig_sine(ray);
    sy = trig_sine(ray + 1024);
    cos_off = trig_sine(offset + 1024);
    if (cos_off < 0) begin
      cos_off = -cos_off;
    end
    stride = (step_shadow == 0) ? 1 : step_shadow;
    d = 0;
    done = 1'b0;
    while (!done && d < MAX_DISTANCE * 4096) begin
      d += stride;
      cx = (longint'(c.pos_x) * 16384 + d * sx) / (longint'(1) << 26);
      cy = (longint'(c.pos_y) * 16384 - d * sy) / (longint'(1) << 26);
      if (cx < 0 || cx >= GRID_SIDE || cy < 0 || cy >= GRID_SIDE) begin
        done = 1'b1;
        d = SCREEN_HEIGHT * 4096;
      end else begin
        k = grid_shadow[cx + cy * GRID_SIDE];
        if (k >= KIND_ONE && k <= KIND_FOUR) begin
          done = 1'b1;
          kind_shadow = k;
          d = (d * cos_off) >> 14;
        end
      end
    end
    if (d <= 0) begin
      row = -1;
    end else begin
      q = (longint'(SCREEN_HEIGHT) << 24) / d;
      row = ((SCREEN_HEIGHT / 2) * 4096 - q) / 4096;
      if (row < -1) row = -1;
      if (row > SCREEN_HEIGHT / 2) row = SCREEN_HEIGHT / 2;
    end
    s.column_out  = c.column;
    s.ceiling_row = ROW_W'(row);
    s.floor_row   = ROW_W'(SCREEN_HEIGHT - row);
    s.wall_color  = wall_shadow[(kind_shadow >= KIND_ONE && kind_shadow <= KIND_FOUR) ?
                                kind_shadow : KIND_ONE];
    s.wall_kind   = kind_shadow;
    span_expected.push_back(s);
  endtask

  // Command driver: bursts of beats separated by random gaps. A beat is replaced only
  // once it was taken at the last rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!cmd.valid || cmd_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cmd.valid <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        cmd_cur = cmd_pending.pop_front();
        cmd.valid      <= 1'b1;
        cmd.command    <= cmd_cur.command;
        cmd.cell_index <= cmd_cur.cell_index;
        cmd.cell_kind  <= cmd_cur.cell_kind;
        cmd.column     <= cmd_cur.column;
        cmd.pos_x      <= cmd_cur.pos_x;
        cmd.pos_y      <= cmd_cur.pos_y;
        cmd.view_angle <= cmd_cur.view_angle;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Span receiver: no stalls, random stalls and a fixed stall pattern in turn.
  always @(negedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 700) % 3)
      0: begin
        span.ready <= 1'b1;
      end
      1: begin
        span.ready <= ($urandom_range(0, 1) == 0);
      end
      default: begin
        span.ready <= (cycle_count % 5) > 1;
      end
    endcase
  end

  // Accepted commands update the shadow; accepted spans are checked in order.
  always @(posedge clk_i) begin
    cmd_taken = rst_ni && cmd.valid && cmd.ready;
    if (rst_ni && cmd.valid && cmd.ready) begin
      if (cmd.command == CMD_WRITE) begin
        grid_shadow[cmd.cell_index] = cmd.cell_kind;
      end else begin
        predict_span(cmd_cur);
      end
    end
    if (rst_ni && span.valid && span.ready) begin
      if (span_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected span beat: column %0d", span.column_out);
        end
      end else begin
        span_beat_t e;
        e = span_expected.pop_front();
        if (span.column_out !== e.column_out || span.ceiling_row !== e.ceiling_row ||
            span.floor_row !== e.floor_row || span.wall_color !== e.wall_color ||
            span.wall_kind !== e.wall_kind) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Span mismatch: expected col %0d ceil %0d floor %0d color %h kind %0d,",
                     e.column_out, e.ceiling_row, e.floor_row, e.wall_color, e.wall_kind);
            $display("  got col %0d ceil %0d floor %0d color %h kind %0d",
                     span.column_out, span.ceiling_row, span.floor_row, span.wall_color,
                     span.wall_kind);
          end
        end
      end
    end
  end

  task automatic queue_write(input int idx, input int kind);
    cmd_beat_t c;
    c = '{CMD_WRITE, 8'(idx), KIND_W'(kind), COL_W'($urandom), POS_W'($urandom),
          POS_W'($urandom), ANG_W'($urandom)};
    cmd_pending.push_back(c);
  endtask

  task automatic queue_cast(input int col, input int px, input int py, input int ang);
    cmd_beat_t c;
    c = '{CMD_CAST, 8'($urandom), KIND_W'($urandom), COL_W'(col), POS_W'(px),
          POS_W'(py), ANG_W'(ang)};
    cmd_pending.push_back(c);
  endtask

  // Mostly casts over a populated map, with cell rewrites mixed in.
  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        queue_write($urandom_range(0, 255),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) :
                    (($urandom_range(0, 1) == 0) ? KIND_EMPTY : $urandom_range(1, 4)));
      end else begin
        queue_cast(($urandom_range(0, 7) == 0) ? $urandom_range(96, 127) :
                   $urandom_range(0, 95), $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Register write over APB: setup then access phase.
  task automatic reg_write(input int idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_STEP_SIZE) begin
      step_shadow = value[STEP_W-1:0];
    end else if (idx >= REG_WALL_ONE && idx <= REG_WALL_FOUR) begin
      wall_shadow[idx - REG_WALL_ONE + 1] = value[COLOR_W-1:0];
    end
  endtask

  task automatic drain_block();
    while (cmd_pending.size() > 0 || cmd.valid || span_expected.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_colors(input logic [15:0] c0, input logic [15:0] c1);
    reg_write(REG_CEILING, c0);
    reg_write(REG_FLOOR, c1);
    reg_write(REG_WALL_ONE, c0);
    reg_write(REG_WALL_TWO, c1);
    reg_write(REG_WALL_THREE, $urandom);
    reg_write(REG_WALL_FOUR, $urandom);
  endtask

  // Player standing in a wall cell, for short marches at tiny steps.
  task automatic tiny_step_casts(input int stride);
    reg_write(REG_STEP_SIZE, stride);
    queue_write(0, KIND_TWO);
    queue_cast(48, 16'h0800, 16'h0800, 0);
    queue_write(0, KIND_EMPTY);
    queue_cast(48, 16'h0800, 16'h0800, 0);
    queue_cast(0, 16'h0100, 16'h0100, $urandom_range(0, 4095));
    drain_block();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd.valid = 1'b0;
    cmd.command = CMD_WRITE;
    cmd.cell_index = '0;
    cmd.cell_kind = '0;
    cmd.column = '0;
    cmd.pos_x = '0;
    cmd.pos_y = '0;
    cmd.view_angle = '0;
    span.ready = 1'b0;
    cmd_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    mismatches = 0;
    cycle_count = 0;
    foreach (grid_shadow[i]) grid_shadow[i] = KIND_EMPTY;
    kind_shadow = KIND_ONE;
    step_shadow = RST_STEP_SIZE;
    wall_shadow[1] = RST_WALL_ONE;
    wall_shadow[2] = RST_WALL_TWO;
    wall_shadow[3] = RST_WALL_THREE;
    wall_shadow[4] = RST_WALL_FOUR;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty map, field extremes, every cell kind, column past the screen.
    queue_cast(0, 0, 0, 0);
    queue_cast(95, 16'hffff, 16'hffff, 12'hfff);
    queue_cast(127, 16'h8000, 16'h8000, 2048);
    for (int k = 0; k < 8; k++) begin
      queue_write(8 * 16 + 9 + k, k);
    end
    queue_write(255, KIND_FOUR);
    queue_write(0, KIND_THREE);
    for (int a = 0; a < 4; a++) begin
      queue_cast(48, 16'h8800, 16'h8800, a * 1024);
    end
    queue_cast(10, 16'h0100, 16'h0100, 3584);
    queue_cast(90, 16'hff00, 16'hff00, 1536);
    queue_cast(48, 16'h1800, 16'h1800, 3584);
    drain_block();

    // Populated map with random registers.
    set_colors($urandom, $urandom);
    reg_write(REG_STEP_SIZE, $urandom_range(200, 4095));
    for (int i = 0; i < 80; i++) begin
      queue_write($urandom_range(0, 255), $urandom_range(1, 4));
    end
    queue_random(350);
    drain_block();

    // Largest step, extreme colors, and a write to an unused register.
    reg_write(REG_STEP_SIZE, 4095);
    set_colors(16'h0000, 16'hffff);
    reg_write(REG_UNKNOWN, $urandom);
    queue_random(300);
    drain_block();

    // Zero and unit steps.
    tiny_step_casts(0);
    tiny_step_casts(1);

    set_colors(16'hffff, 16'h0000);
    reg_write(REG_STEP_SIZE, $urandom_range(64, 4095));
    queue_random(300);
    drain_block();
    reg_write(REG_STEP_SIZE, $urandom_range(300, 1200));
    set_colors($urandom, $urandom);
    queue_random(300);
    drain_block();

    if (mismatches == 0) begin
      $display("PASS raycast_column_span_core");
    end else begin
      $display("FAIL raycast_column_span_core");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("FAIL raycast_column_span_core");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/rcs_pkg.sv
hw/rtl/rcs_cmd_if.sv
hw/rtl/rcs_span_if.sv
hw/rtl/rcs_ram.sv
hw/rtl/rcs_regs.sv
hw/rtl/rcs_ctrl.sv
hw/rtl/rcs_dp.sv
hw/rtl/raycast_column_span_core.sv
hw/rtl/rcs_checker.sv
bench/tb_raycast_column_span_core.sv
